@@ rtl/wsf_pkg.sv @@
// Shared constants, codes and helpers for the windowed-sinc FIR coefficient generator.
// Holds the quarter-wave sine table builder used by the sine ROM.
// Depends on nothing.
package wsf_pkg;

   // Sizing
   localparam int MAX_TAPS         = 256;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int OFF_W            = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_ADDR_W      = OFF_W + 1;
   localparam int PHASE_W          = OFF_W + 2;
   localparam int WQ_W             = PHASE_W + 2;
   localparam int SINE_W           = 17;
   localparam int TAP_W            = 8;
   localparam int M_W              = $clog2(MAX_TAPS);
   localparam int RATIO_W          = 24;
   localparam int PHASE_FRAC       = RATIO_W + 1;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 18;

   // Fixed-point constants
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int unsigned     TWO_OVER_PI_Q24 = 32'd10680708;
   localparam int unsigned     MIN_SAMPLE_RATE = 32'd1000;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_TYPE = 3'd0,
      CSR_WINDOW_KIND = 3'd1,
      CSR_NUM_TAPS    = 3'd2,
      CSR_CUTOFF_LOW  = 3'd3,
      CSR_CUTOFF_HIGH = 3'd4,
      CSR_SAMPLE_RATE = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      FILTER_LOWPASS  = 2'd0,
      FILTER_HIGHPASS = 2'd1,
      FILTER_BANDPASS = 2'd2,
      FILTER_BANDSTOP = 2'd3
   } filter_type_type;

   typedef enum logic [1:0] {
      WINDOW_BLACKMAN = 2'd0,
      WINDOW_HANNING  = 2'd1,
      WINDOW_HAMMING  = 2'd2,
      WINDOW_RECT     = 2'd3
   } window_kind_type;

   typedef logic [SINE_W-1:0] sine_table_type [0:SINE_TABLE_DEPTH];

   // ROM address and sign for one phase of the full turn.
   typedef struct packed {
      logic [SINE_ADDR_W-1:0] addr;
      logic                   neg;
   } sine_addr_type;

   // Quarter-wave sine table in Q.16, built by a Taylor series at elaboration.
   function automatic sine_table_type build_sine_table();
      sine_table_type    tab;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint            sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int j = 1; j <= 8; j++) begin
            term = (term * x2) >> 30;
            // Each term is divided by (2j)(2j+1) on top of the previous one.
            case (j)
               1:       term = term / 6;
               2:       term = term / 20;
               3:       term = term / 42;
               4:       term = term / 72;
               5:       term = term / 110;
               6:       term = term / 156;
               7:       term = term / 210;
               default: term = term / 272;
            endcase
            if ((j % 2) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         tab[k] = SINE_W'((longint'(sum) + 8192) >> 14);
      end
      return tab;
   endfunction

   // Fold a full-turn phase onto the quarter-wave table.
   function automatic sine_addr_type sine_fold(logic [PHASE_W-1:0] q);
      sine_addr_type f;
      f.neg = q[PHASE_W-1];
      if (q[PHASE_W-2]) begin
         f.addr = SINE_ADDR_W'(SINE_TABLE_DEPTH) - {1'b0, q[OFF_W-1:0]};
      end else begin
         f.addr = {1'b0, q[OFF_W-1:0]};
      end
      return f;
   endfunction

   // Give a table magnitude its sign.
   function automatic logic signed [18:0] apply_sign(logic [16:0] mag, logic neg);
      logic signed [18:0] v;
      v = $signed({2'b00, mag});
      return neg ? -v : v;
   endfunction

endpackage

@@ rtl/windowed_sinc_fir_coefficient_gen.sv @@
// The result strobe rsp_valid rises once the taken request has passed every pipeline register.
// Throughput: one request per cycle while busy is low, through a nine-register pipeline.
// After reset and after each configuration write, busy is high while a bit-serial
// divider forms both cutoff ratios, one quotient bit a cycle; a further write restarts it.
// Reset is synchronous and active high; it restores the register defaults.
// Depends on wsf_pkg and wsf_sine_rom.
module windowed_sinc_fir_coefficient_gen (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [wsf_pkg::TAP_W-1:0]       req_tap_index,
   output logic                            rsp_valid,
   output logic signed [15:0]              rsp_coefficient,
   output logic [wsf_pkg::TAP_W-1:0]       rsp_coeff_index,
   output logic                            rsp_saturated,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wsf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wsf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TAP_W   = wsf_pkg::TAP_W;
   localparam int M_W     = wsf_pkg::M_W;
   localparam int WQ_W    = wsf_pkg::WQ_W;
   localparam int PHASE_W = wsf_pkg::PHASE_W;
   localparam int RATIO_W = wsf_pkg::RATIO_W;
   localparam int SINE_W  = wsf_pkg::SINE_W;
   localparam int WDIV_S1 = (WQ_W - 1 + 2) / 3;
   localparam int WDIV_S2 = (WQ_W - 1 - WDIV_S1) / 2;
   localparam int WDIV_S3 = WQ_W - 1 - WDIV_S1 - WDIV_S2;
   localparam int RCNT_W  = $clog2(RATIO_W + 1);

   // Configuration registers
   wsf_pkg::filter_type_type filter_type_ff;
   wsf_pkg::window_kind_type window_kind_ff;
   logic [8:0]               num_taps_ff;
   logic [16:0]              cutoff_low_ff;
   logic [16:0]              cutoff_high_ff;
   logic [17:0]              sample_rate_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_type_ff <= wsf_pkg::FILTER_LOWPASS;
         window_kind_ff <= wsf_pkg::WINDOW_BLACKMAN;
         num_taps_ff    <= 9'd64;
         cutoff_low_ff  <= 17'd1000;
         cutoff_high_ff <= 17'd3000;
         sample_rate_ff <= 18'd48000;
      end else if (csr_valid && csr_ready) begin
         case (wsf_pkg::csr_index_type'(csr_index))
            wsf_pkg::CSR_FILTER_TYPE: filter_type_ff <= wsf_pkg::filter_type_type'(csr_wdata[1:0]);
            wsf_pkg::CSR_WINDOW_KIND: window_kind_ff <= wsf_pkg::window_kind_type'(csr_wdata[1:0]);
            wsf_pkg::CSR_NUM_TAPS:    num_taps_ff    <= csr_wdata[8:0];
            wsf_pkg::CSR_CUTOFF_LOW:  cutoff_low_ff  <= csr_wdata[16:0];
            wsf_pkg::CSR_CUTOFF_HIGH: cutoff_high_ff <= csr_wdata[16:0];
            wsf_pkg::CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata[17:0];
            default: ;
         endcase
      end
   end

   // Cutoff ratio divider: floor(f * 2^24 / fs), both cutoffs side by side; f >= fs gives all ones.
   logic                rdiv_dirty_ff;
   logic [RCNT_W-1:0]   rdiv_count_ff;
   logic [17:0]         rem_lo_ff, rem_hi_ff;
   logic [RATIO_W-1:0]  quot_lo_ff, quot_hi_ff;
   logic                rsat_lo_ff, rsat_hi_ff;
   logic [17:0]         fs_eff;
   logic [18:0]         rdbl_lo, rdbl_hi;
   logic                rge_lo, rge_hi;
   logic [RATIO_W-1:0]  ratio_lo, ratio_hi;

   assign fs_eff  = (sample_rate_ff < 18'(wsf_pkg::MIN_SAMPLE_RATE)) ?
                    18'(wsf_pkg::MIN_SAMPLE_RATE) : sample_rate_ff;
   assign rdbl_lo = {rem_lo_ff, 1'b0};
   assign rdbl_hi = {rem_hi_ff, 1'b0};
   assign rge_lo  = rdbl_lo >= {1'b0, fs_eff};
   assign rge_hi  = rdbl_hi >= {1'b0, fs_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rdiv_dirty_ff <= 1'b1;
         rdiv_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         rdiv_dirty_ff <= 1'b1;
      end else if (rdiv_dirty_ff) begin
         rdiv_dirty_ff <= 1'b0;
         rdiv_count_ff <= RCNT_W'(RATIO_W);
         rem_lo_ff     <= {1'b0, cutoff_low_ff};
         rem_hi_ff     <= {1'b0, cutoff_high_ff};
         rsat_lo_ff    <= {1'b0, cutoff_low_ff} >= fs_eff;
         rsat_hi_ff    <= {1'b0, cutoff_high_ff} >= fs_eff;
         quot_lo_ff    <= '0;
         quot_hi_ff    <= '0;
      end else if (rdiv_count_ff != '0) begin
         rdiv_count_ff <= rdiv_count_ff - 1'b1;
         rem_lo_ff     <= rge_lo ? 18'(rdbl_lo - {1'b0, fs_eff}) : rdbl_lo[17:0];
         rem_hi_ff     <= rge_hi ? 18'(rdbl_hi - {1'b0, fs_eff}) : rdbl_hi[17:0];
         quot_lo_ff    <= {quot_lo_ff[RATIO_W-2:0], rge_lo};
         quot_hi_ff    <= {quot_hi_ff[RATIO_W-2:0], rge_hi};
      end
   end

   assign ratio_lo = rsat_lo_ff ? '1 : quot_lo_ff;
   assign ratio_hi = rsat_hi_ff ? '1 : quot_hi_ff;
   assign busy     = rdiv_dirty_ff || (rdiv_count_ff != '0);

   // Effective tap count and span
   logic [8:0]     n_eff;
   logic [M_W-1:0] m;

   always_comb begin
      if (num_taps_ff < 9'd3) begin
         n_eff = 9'd3;
      end else if (num_taps_ff > 9'(wsf_pkg::MAX_TAPS)) begin
         n_eff = 9'(wsf_pkg::MAX_TAPS);
      end else begin
         n_eff = num_taps_ff;
      end
      m = M_W'(n_eff - 9'd1);
   end

   // Stage 0: request register
   logic             s0_valid_ff;
   logic [TAP_W-1:0] s0_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
      s0_idx_ff <= req_tap_index;
   end

   // Stage 1: tap geometry and the first window quotient bits
   logic [8:0]      twice, m_ext, d_full;
   logic [M_W-1:0]  w1_rem;
   logic [M_W:0]    w1_dbl;
   logic [WQ_W-1:0] w1_quo;

   logic             s1_valid_ff, s1_in_range_ff, s1_centre_ff, s1_exact_ff;
   logic [TAP_W-1:0] s1_idx_ff;
   logic [M_W-1:0]   s1_d_ff, s1_wrem_ff;
   logic [WQ_W-1:0]  s1_wquo_ff;

   always_comb begin
      twice  = {s0_idx_ff, 1'b0};
      m_ext  = {1'b0, m};
      d_full = (twice > m_ext) ? twice - m_ext : m_ext - twice;
      if (s0_idx_ff >= m) begin
         w1_rem = M_W'(s0_idx_ff - m);
         w1_quo = WQ_W'(1);
      end else begin
         w1_rem = s0_idx_ff;
         w1_quo = '0;
      end
      w1_dbl = '0;
      for (int k = 0; k < WDIV_S1; k++) begin
         w1_dbl = {w1_rem, 1'b0};
         if (w1_dbl >= {1'b0, m}) begin
            w1_rem = M_W'(w1_dbl - {1'b0, m});
            w1_quo = {w1_quo[WQ_W-2:0], 1'b1};
         end else begin
            w1_rem = w1_dbl[M_W-1:0];
            w1_quo = {w1_quo[WQ_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_idx_ff      <= s0_idx_ff;
      s1_in_range_ff <= {1'b0, s0_idx_ff} < n_eff;
      s1_centre_ff   <= s0_idx_ff == TAP_W'(m >> 1);
      s1_exact_ff    <= twice == m_ext;
      s1_d_ff        <= M_W'(d_full);
      s1_wrem_ff     <= w1_rem;
      s1_wquo_ff     <= w1_quo;
   end

   // Stage 2: sinc phases and the middle window quotient bits
   logic [31:0]     prod_lo, prod_hi;
   logic [M_W-1:0]  w2_rem;
   logic [M_W:0]    w2_dbl;
   logic [WQ_W-1:0] w2_quo;

   logic                  s2_valid_ff, s2_in_range_ff, s2_centre_ff, s2_exact_ff;
   logic [TAP_W-1:0]      s2_idx_ff;
   logic [M_W-1:0]        s2_d_ff, s2_wrem_ff;
   logic [WQ_W-1:0]       s2_wquo_ff;
   wsf_pkg::sine_addr_type s2_sa_lo_ff, s2_sa_hi_ff;

   assign prod_lo = 32'(ratio_lo) * 32'(s1_d_ff);
   assign prod_hi = 32'(ratio_hi) * 32'(s1_d_ff);

   always_comb begin
      w2_rem = s1_wrem_ff;
      w2_quo = s1_wquo_ff;
      w2_dbl = '0;
      for (int k = 0; k < WDIV_S2; k++) begin
         w2_dbl = {w2_rem, 1'b0};
         if (w2_dbl >= {1'b0, m}) begin
            w2_rem = M_W'(w2_dbl - {1'b0, m});
            w2_quo = {w2_quo[WQ_W-2:0], 1'b1};
         end else begin
            w2_rem = w2_dbl[M_W-1:0];
            w2_quo = {w2_quo[WQ_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_idx_ff      <= s1_idx_ff;
      s2_in_range_ff <= s1_in_range_ff;
      s2_centre_ff   <= s1_centre_ff;
      s2_exact_ff    <= s1_exact_ff;
      s2_d_ff        <= s1_d_ff;
      s2_wrem_ff     <= w2_rem;
      s2_wquo_ff     <= w2_quo;
      s2_sa_lo_ff    <= wsf_pkg::sine_fold(prod_lo[wsf_pkg::PHASE_FRAC-1 -: PHASE_W]);
      s2_sa_hi_ff    <= wsf_pkg::sine_fold(prod_hi[wsf_pkg::PHASE_FRAC-1 -: PHASE_W]);
   end

   // Stage 3: sine read for both sinc terms, last window quotient bits
   logic [SINE_W-1:0] sin_lo, sin_hi, cos_1, cos_2;
   logic [M_W-1:0]    w3_rem;
   logic [M_W:0]      w3_dbl;
   logic [WQ_W-1:0]   w3_quo;

   logic             s3_valid_ff, s3_in_range_ff, s3_centre_ff, s3_exact_ff;
   logic             s3_neg_lo_ff, s3_neg_hi_ff;
   logic [TAP_W-1:0] s3_idx_ff;
   logic [M_W-1:0]   s3_d_ff;
   logic [WQ_W-1:0]  s3_wq_ff;

   always_comb begin
      w3_rem = s2_wrem_ff;
      w3_quo = s2_wquo_ff;
      w3_dbl = '0;
      for (int k = 0; k < WDIV_S3; k++) begin
         w3_dbl = {w3_rem, 1'b0};
         if (w3_dbl >= {1'b0, m}) begin
            w3_rem = M_W'(w3_dbl - {1'b0, m});
            w3_quo = {w3_quo[WQ_W-2:0], 1'b1};
         end else begin
            w3_rem = w3_dbl[M_W-1:0];
            w3_quo = {w3_quo[WQ_W-2:0], 1'b0};
         end
      end
   end

   wsf_sine_rom u_rom_sinc (
      .clock     (clock),
      .rd_addr_a (s2_sa_lo_ff.addr),
      .rd_addr_b (s2_sa_hi_ff.addr),
      .rd_data_a (sin_lo),
      .rd_data_b (sin_hi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_idx_ff      <= s2_idx_ff;
      s3_in_range_ff <= s2_in_range_ff;
      s3_centre_ff   <= s2_centre_ff;
      s3_exact_ff    <= s2_exact_ff;
      s3_d_ff        <= s2_d_ff;
      s3_neg_lo_ff   <= s2_sa_lo_ff.neg;
      s3_neg_hi_ff   <= s2_sa_hi_ff.neg;
      s3_wq_ff       <= w3_quo;
   end

   // Stage 4: scale sines by 2/pi, read both window cosines
   logic [40:0]            smul_lo, smul_hi;
   logic [PHASE_W-1:0]     cph_1, cph_2;
   wsf_pkg::sine_addr_type ca_1, ca_2;

   logic             s4_valid_ff, s4_in_range_ff, s4_centre_ff, s4_exact_ff;
   logic             s4_neg_lo_ff, s4_neg_hi_ff, s4_cneg1_ff, s4_cneg2_ff;
   logic [TAP_W-1:0] s4_idx_ff;
   logic [M_W-1:0]   s4_d_ff;
   logic [15:0]      s4_num_lo_ff, s4_num_hi_ff;

   assign smul_lo = 41'(sin_lo) * 41'(wsf_pkg::TWO_OVER_PI_Q24);
   assign smul_hi = 41'(sin_hi) * 41'(wsf_pkg::TWO_OVER_PI_Q24);
   // The cosine is the sine a quarter turn on; q1 is q2 halved.
   assign cph_1   = PHASE_W'(s3_wq_ff >> 1) + PHASE_W'(wsf_pkg::SINE_TABLE_DEPTH);
   assign cph_2   = s3_wq_ff[PHASE_W-1:0] + PHASE_W'(wsf_pkg::SINE_TABLE_DEPTH);
   assign ca_1    = wsf_pkg::sine_fold(cph_1);
   assign ca_2    = wsf_pkg::sine_fold(cph_2);

   wsf_sine_rom u_rom_window (
      .clock     (clock),
      .rd_addr_a (ca_1.addr),
      .rd_addr_b (ca_2.addr),
      .rd_data_a (cos_1),
      .rd_data_b (cos_2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_idx_ff      <= s3_idx_ff;
      s4_in_range_ff <= s3_in_range_ff;
      s4_centre_ff   <= s3_centre_ff;
      s4_exact_ff    <= s3_exact_ff;
      s4_d_ff        <= s3_d_ff;
      s4_neg_lo_ff   <= s3_neg_lo_ff;
      s4_neg_hi_ff   <= s3_neg_hi_ff;
      s4_cneg1_ff    <= ca_1.neg;
      s4_cneg2_ff    <= ca_2.neg;
      s4_num_lo_ff   <= smul_lo[39:24];
      s4_num_hi_ff   <= smul_hi[39:24];
   end

   // Stage 5: upper half of the sinc division, window products
   logic [M_W-1:0] a_rem_lo, a_rem_hi;
   logic [M_W:0]   a_dbl;
   logic [7:0]     a_quo_lo, a_quo_hi;
   logic [31:0]    p_30147, p_5243;
   logic signed [18:0] c1_signed;

   logic             s5_valid_ff, s5_in_range_ff, s5_centre_ff, s5_exact_ff;
   logic             s5_neg_lo_ff, s5_neg_hi_ff;
   logic [TAP_W-1:0] s5_idx_ff;
   logic [M_W-1:0]   s5_d_ff, s5_rem_lo_ff, s5_rem_hi_ff;
   logic [7:0]       s5_quo_lo_ff, s5_quo_hi_ff, s5_num_lo_ff, s5_num_hi_ff;
   logic signed [18:0] s5_half_c1_ff, s5_k5243_ff, s5_k30147_ff, s5_hann_ff;

   always_comb begin
      a_rem_lo = '0;
      a_rem_hi = '0;
      a_quo_lo = '0;
      a_quo_hi = '0;
      a_dbl    = '0;
      for (int k = 15; k >= 8; k--) begin
         a_dbl = {a_rem_lo, s4_num_lo_ff[k]};
         if (a_dbl >= {1'b0, s4_d_ff}) begin
            a_rem_lo = M_W'(a_dbl - {1'b0, s4_d_ff});
            a_quo_lo = {a_quo_lo[6:0], 1'b1};
         end else begin
            a_rem_lo = a_dbl[M_W-1:0];
            a_quo_lo = {a_quo_lo[6:0], 1'b0};
         end
         a_dbl = {a_rem_hi, s4_num_hi_ff[k]};
         if (a_dbl >= {1'b0, s4_d_ff}) begin
            a_rem_hi = M_W'(a_dbl - {1'b0, s4_d_ff});
            a_quo_hi = {a_quo_hi[6:0], 1'b1};
         end else begin
            a_rem_hi = a_dbl[M_W-1:0];
            a_quo_hi = {a_quo_hi[6:0], 1'b0};
         end
      end
   end

   assign p_30147   = 32'(cos_1) * 32'd30147;
   assign p_5243    = 32'(cos_2) * 32'd5243;
   assign c1_signed = wsf_pkg::apply_sign(cos_1, s4_cneg1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_idx_ff      <= s4_idx_ff;
      s5_in_range_ff <= s4_in_range_ff;
      s5_centre_ff   <= s4_centre_ff;
      s5_exact_ff    <= s4_exact_ff;
      s5_neg_lo_ff   <= s4_neg_lo_ff;
      s5_neg_hi_ff   <= s4_neg_hi_ff;
      s5_d_ff        <= s4_d_ff;
      s5_rem_lo_ff   <= a_rem_lo;
      s5_rem_hi_ff   <= a_rem_hi;
      s5_quo_lo_ff   <= a_quo_lo;
      s5_quo_hi_ff   <= a_quo_hi;
      s5_num_lo_ff   <= s4_num_lo_ff[7:0];
      s5_num_hi_ff   <= s4_num_hi_ff[7:0];
      s5_half_c1_ff  <= wsf_pkg::apply_sign(cos_1 >> 1, s4_cneg1_ff);
      s5_k30147_ff   <= wsf_pkg::apply_sign(17'(p_30147[31:16]), s4_cneg1_ff);
      s5_k5243_ff    <= wsf_pkg::apply_sign(17'(p_5243[31:16]), s4_cneg2_ff);
      s5_hann_ff     <= (19'sd65536 - c1_signed) >>> 1;
   end

   // Stage 6: lower half of the sinc division, window selection
   logic [M_W-1:0]     b_rem_lo, b_rem_hi;
   logic [M_W:0]       b_dbl;
   logic [15:0]        b_quo_lo, b_quo_hi;
   logic signed [17:0] sinc_lo, sinc_hi;
   logic signed [18:0] win;

   logic             s6_valid_ff, s6_in_range_ff, s6_centre_ff;
   logic [TAP_W-1:0] s6_idx_ff;
   logic signed [17:0] s6_sinc_lo_ff, s6_sinc_hi_ff;
   logic signed [18:0] s6_win_ff;

   always_comb begin
      b_rem_lo = s5_rem_lo_ff;
      b_rem_hi = s5_rem_hi_ff;
      b_quo_lo = {8'd0, s5_quo_lo_ff};
      b_quo_hi = {8'd0, s5_quo_hi_ff};
      b_dbl    = '0;
      for (int k = 7; k >= 0; k--) begin
         b_dbl = {b_rem_lo, s5_num_lo_ff[k]};
         if (b_dbl >= {1'b0, s5_d_ff}) begin
            b_rem_lo = M_W'(b_dbl - {1'b0, s5_d_ff});
            b_quo_lo = {b_quo_lo[14:0], 1'b1};
         end else begin
            b_rem_lo = b_dbl[M_W-1:0];
            b_quo_lo = {b_quo_lo[14:0], 1'b0};
         end
         b_dbl = {b_rem_hi, s5_num_hi_ff[k]};
         if (b_dbl >= {1'b0, s5_d_ff}) begin
            b_rem_hi = M_W'(b_dbl - {1'b0, s5_d_ff});
            b_quo_hi = {b_quo_hi[14:0], 1'b1};
         end else begin
            b_rem_hi = b_dbl[M_W-1:0];
            b_quo_hi = {b_quo_hi[14:0], 1'b0};
         end
      end

      // At the exact centre the sinc is 2*fc.
      if (s5_exact_ff) begin
         sinc_lo = $signed({1'b0, 17'(ratio_lo >> 7)});
         sinc_hi = $signed({1'b0, 17'(ratio_hi >> 7)});
      end else begin
         sinc_lo = s5_neg_lo_ff ? -$signed({2'b00, b_quo_lo}) : $signed({2'b00, b_quo_lo});
         sinc_hi = s5_neg_hi_ff ? -$signed({2'b00, b_quo_hi}) : $signed({2'b00, b_quo_hi});
      end

      case (window_kind_ff)
         wsf_pkg::WINDOW_BLACKMAN: win = 19'sd27525 - s5_half_c1_ff + s5_k5243_ff;
         wsf_pkg::WINDOW_HANNING:  win = s5_hann_ff;
         wsf_pkg::WINDOW_HAMMING:  win = 19'sd35389 - s5_k30147_ff;
         default:                  win = 19'sd65536;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_idx_ff      <= s5_idx_ff;
      s6_in_range_ff <= s5_in_range_ff;
      s6_centre_ff   <= s5_centre_ff;
      s6_sinc_lo_ff  <= sinc_lo;
      s6_sinc_hi_ff  <= sinc_hi;
      s6_win_ff      <= win;
   end

   // Stage 7: window the two sinc terms, products truncated toward zero
   logic [16:0] mag_lo, mag_hi;
   logic [17:0] mag_w;
   logic [34:0] lpm_lo, lpm_hi;
   logic signed [19:0] lp_lo, lp_hi;

   logic             s7_valid_ff, s7_in_range_ff, s7_centre_ff;
   logic [TAP_W-1:0] s7_idx_ff;
   logic signed [19:0] s7_lp_lo_ff, s7_lp_hi_ff;

   always_comb begin
      mag_lo = s6_sinc_lo_ff[17] ? 17'(-s6_sinc_lo_ff) : 17'(s6_sinc_lo_ff);
      mag_hi = s6_sinc_hi_ff[17] ? 17'(-s6_sinc_hi_ff) : 17'(s6_sinc_hi_ff);
      mag_w  = s6_win_ff[18] ? 18'(-s6_win_ff) : 18'(s6_win_ff);
      lpm_lo = 35'(mag_lo) * 35'(mag_w);
      lpm_hi = 35'(mag_hi) * 35'(mag_w);
      lp_lo  = (s6_sinc_lo_ff[17] ^ s6_win_ff[18]) ?
               -$signed({1'b0, lpm_lo[34:16]}) : $signed({1'b0, lpm_lo[34:16]});
      lp_hi  = (s6_sinc_hi_ff[17] ^ s6_win_ff[18]) ?
               -$signed({1'b0, lpm_hi[34:16]}) : $signed({1'b0, lpm_hi[34:16]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
      s7_idx_ff      <= s6_idx_ff;
      s7_in_range_ff <= s6_in_range_ff;
      s7_centre_ff   <= s6_centre_ff;
      s7_lp_lo_ff    <= lp_lo;
      s7_lp_hi_ff    <= lp_hi;
   end

   // Stage 8: combine by filter type, halve to Q1.15 and clamp
   logic signed [21:0] delta, vsum, vadj, vhalf;
   logic signed [15:0] coef;
   logic               sat;

   logic                     rsp_valid_ff, rsp_saturated_ff;
   logic signed [15:0]       rsp_coefficient_ff;
   logic [TAP_W-1:0]         rsp_coeff_index_ff;

   always_comb begin
      delta = s7_centre_ff ? 22'sd65536 : 22'sd0;
      case (filter_type_ff)
         wsf_pkg::FILTER_LOWPASS:  vsum = 22'(s7_lp_lo_ff);
         wsf_pkg::FILTER_HIGHPASS: vsum = delta - 22'(s7_lp_lo_ff);
         wsf_pkg::FILTER_BANDPASS: vsum = 22'(s7_lp_hi_ff) - 22'(s7_lp_lo_ff);
         default:                  vsum = 22'(s7_lp_lo_ff) - 22'(s7_lp_hi_ff) + delta;
      endcase
      // Halving toward zero: bias negative values by one before the shift.
      vadj  = vsum + (vsum[21] ? 22'sd1 : 22'sd0);
      vhalf = vadj >>> 1;
      if (!s7_in_range_ff) begin
         coef = '0;
         sat  = 1'b0;
      end else if (vhalf > 22'sd32767) begin
         coef = 16'sh7fff;
         sat  = 1'b1;
      end else if (vhalf < -22'sd32768) begin
         coef = -16'sh8000;
         sat  = 1'b1;
      end else begin
         coef = 16'(vhalf);
         sat  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s7_valid_ff;
      end
      rsp_coefficient_ff <= coef;
      rsp_coeff_index_ff <= s7_idx_ff;
      rsp_saturated_ff   <= sat;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coefficient_ff;
   assign rsp_coeff_index = rsp_coeff_index_ff;
   assign rsp_saturated   = rsp_saturated_ff;

endmodule

@@ rtl/wsf_sine_rom.sv @@
// Dual-read quarter-wave sine ROM with registered read data.
// Depends on wsf_pkg for the table contents and widths.
module wsf_sine_rom (
   input  logic                            clock,
   input  logic [wsf_pkg::SINE_ADDR_W-1:0] rd_addr_a,
   input  logic [wsf_pkg::SINE_ADDR_W-1:0] rd_addr_b,
   output logic [wsf_pkg::SINE_W-1:0]      rd_data_a,
   output logic [wsf_pkg::SINE_W-1:0]      rd_data_b
);

   localparam wsf_pkg::sine_table_type SINE_ROM = wsf_pkg::build_sine_table();

   logic [wsf_pkg::SINE_W-1:0] rd_data_a_ff;
   logic [wsf_pkg::SINE_W-1:0] rd_data_b_ff;

   // Both ports read in the same cycle; the data appears in the next cycle.
   always_ff @(posedge clock) begin
      rd_data_a_ff <= SINE_ROM[rd_addr_a];
      rd_data_b_ff <= SINE_ROM[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ rtl/wsf_checker.sv @@
// Port-level checks for the windowed-sinc FIR coefficient generator, bound to the top level.
// Depends on windowed_sinc_fir_coefficient_gen and wsf_pkg for widths.
module wsf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [wsf_pkg::TAP_W-1:0]       req_tap_index,
   input logic                            rsp_valid,
   input logic signed [15:0]              rsp_coefficient,
   input logic [wsf_pkg::TAP_W-1:0]       rsp_coeff_index,
   input logic                            rsp_saturated,
   input logic                            csr_valid,
   input logic                            csr_ready
);

   // The cutoff ratios are recomputed after reset, so requests are held off.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // A configuration write restarts the ratio division.
   a_busy_after_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("busy low after a configuration write");

   // Every request taken returns its own tap on rsp_coeff_index.
   a_latency_echo: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##9 (rsp_valid && rsp_coeff_index == $past(req_tap_index, 9)))
      else $error("result missing or tap index wrong");

   // No result without a request taken at the matching edge.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 9))
      else $error("result without a request");

   // A clamped result sits on one of the two rails.
   a_sat_rails: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
      (rsp_coefficient == 16'sh7fff || rsp_coefficient == -16'sh8000))
      else $error("saturated flag with a value off the rails");

endmodule

bind windowed_sinc_fir_coefficient_gen wsf_checker u_wsf_checker (.*);
